// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define LPR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check that a condition is followed in the next cycle by an expression.
`define LPR_ASSERT_NEXT(lbl, clk, rstn, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) else $error(msg);
`else
`define LPR_ASSERT(lbl, clk, rstn, prop, msg)
`define LPR_ASSERT_NEXT(lbl, clk, rstn, cond, expr, msg)
`endif

`endif

// ----- rtl/core/lpr_pkg.sv -----
package lpr_pkg;

    localparam int TABLE_DEPTH_DEF    = 16;
    localparam int NUM_INTERFACES_DEF = 8;

    localparam logic [5:0]  MAX_PREFIX = 6'd32;
    localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_LOOKUP = 1'b1
    } mode_t;

    typedef enum logic [2:0] {
        ST_FORWARD         = 3'd0,
        ST_NO_ROUTE        = 3'd1,
        ST_BACK_TO_INGRESS = 3'd2,
        ST_TTL_EXPIRED     = 3'd3,
        ST_INSERTED        = 3'd4,
        ST_INACTIVE        = 3'd5,
        ST_FULL            = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DRAIN,
        FSM_RESOLVE,
        FSM_DONE
    } fsm_t;

    typedef struct packed {
        logic       mode;
        logic [31:0] address;
        logic [5:0] prefix_len;
        logic [2:0] route_interface;
        logic [2:0] ingress_interface;
        logic [7:0] ttl;
    } in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] out_interface;
        logic [7:0] out_ttl;
    } out_t;

    // One stored route as it sits in the table memory.
    typedef struct packed {
        logic [31:0] network;
        logic [5:0]  length;
        logic [2:0]  port;
    } route_t;

    typedef struct packed {
        logic clear;
        logic rd_valid;
    } match_ctrl_t;

    typedef struct packed {
        logic       found;
        logic [2:0] port;
    } match_res_t;

endpackage

// ----- rtl/core/lpr_ram.sv -----
module lpr_ram #(
    parameter int  WIDTH = 1,
    parameter int  DEPTH = 2,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one entry, read one entry with registered data.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/lpr_match.sv -----
module lpr_match (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lpr_pkg::match_ctrl_t ctrl,
    input  lpr_pkg::route_t      entry,
    input  logic [31:0]          dest,
    output lpr_pkg::match_res_t  res
);
    import lpr_pkg::*;

    logic        found_reg, found_next;
    logic [5:0]  best_len_reg, best_len_next;
    logic [2:0]  best_port_reg, best_port_next;
    logic [31:0] mask;
    logic        hit;
    logic        take;

    // Compare the route just read against the destination.
    always_comb begin
        mask = ~(ALL_ONES >> entry.length);
        hit  = ((dest ^ entry.network) & mask) == 32'd0;
        take = ctrl.rd_valid && hit && (!found_reg || (entry.length > best_len_reg));
    end

    // Keep the longest match; earlier routes win ties.
    always_comb begin
        found_next     = found_reg;
        best_len_next  = best_len_reg;
        best_port_next = best_port_reg;
        if (ctrl.clear) begin
            found_next = 1'b0;
        end else if (take) begin
            found_next     = 1'b1;
            best_len_next  = entry.length;
            best_port_next = entry.port;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_len_reg  <= best_len_next;
        best_port_reg <= best_port_next;
    end

    assign res.found = found_reg;
    assign res.port  = best_port_reg;

endmodule

// ----- rtl/core/longest_prefix_route_table.sv -----
// Insert, expired TTL or empty table: the item goes from idle straight to the done
// state, which loads the output and raises m_valid; new items are taken only in idle.
// Other lookups: the scan state reads every stored route in turn, then the drain and
// resolve states pass before done raises m_valid; one stored route is read per cycle.
// A result held by m_ready low stalls the block until the output register frees.
// Reset clears route count, active mask, FSM and output valid; table stays undefined.
`include "assert_macros.svh"

module longest_prefix_route_table #(
    parameter int TABLE_DEPTH    = lpr_pkg::TABLE_DEPTH_DEF,
    parameter int NUM_INTERFACES = lpr_pkg::NUM_INTERFACES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [7:0]    cfg_wr_data,
    input  logic          s_valid,
    output logic          s_ready,
    input  lpr_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output lpr_pkg::out_t m_data
);
    import lpr_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    fsm_t          state_reg, state_next;
    logic [7:0]    active_mask_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic          rd_valid_reg;
    in_t           lookup_reg;
    out_t          result_reg, result_next;
    logic          m_valid_reg, m_valid_next;
    out_t          m_data_reg;

    logic          accept;
    logic          port_ok;
    logic          table_full;
    logic          ttl_low;
    logic          table_empty;
    logic          scan_last;
    logic          out_free;
    logic          rd_en;
    logic          wr_en;
    logic          load_out;
    logic [5:0]    plen_sat;
    route_t        wr_route;
    route_t        rd_route;
    match_ctrl_t   mctrl;
    match_res_t    mres;

    // Decode the incoming item.
    always_comb begin
        accept      = s_valid && s_ready;
        port_ok     = (int'(s_data.route_interface) < NUM_INTERFACES)
                      && active_mask_reg[s_data.route_interface];
        table_full  = count_reg == CW'(TABLE_DEPTH);
        ttl_low     = s_data.ttl <= 8'd1;
        table_empty = count_reg == '0;
        scan_last   = (CW'(rd_idx_reg) + CW'(1)) == count_reg;
        out_free    = !m_valid_reg || m_ready;
        plen_sat    = (s_data.prefix_len > MAX_PREFIX) ? MAX_PREFIX : s_data.prefix_len;
        wr_route.network = s_data.address;
        wr_route.length  = plen_sat;
        wr_route.port    = s_data.route_interface;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: begin
                if (s_valid) begin
                    if (s_data.mode == MODE_INSERT || ttl_low || table_empty) begin
                        state_next = FSM_DONE;
                    end else begin
                        state_next = FSM_SCAN;
                    end
                end
            end
            FSM_SCAN: begin
                if (scan_last) begin
                    state_next = FSM_DRAIN;
                end
            end
            FSM_DRAIN:   state_next = FSM_RESOLVE;
            FSM_RESOLVE: state_next = FSM_DONE;
            FSM_DONE: begin
                if (out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default:     state_next = FSM_IDLE;
        endcase
    end

    // Control outputs of the FSM.
    always_comb begin
        s_ready     = 1'b0;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        load_out    = 1'b0;
        mctrl.clear = 1'b0;
        unique case (state_reg)
            FSM_IDLE: begin
                s_ready     = 1'b1;
                wr_en       = s_valid && (s_data.mode == MODE_INSERT) && port_ok && !table_full;
                mctrl.clear = s_valid;
            end
            FSM_SCAN:    rd_en = 1'b1;
            FSM_DRAIN:   rd_en = 1'b0;
            FSM_RESOLVE: rd_en = 1'b0;
            FSM_DONE:    load_out = out_free;
            default:     rd_en = 1'b0;
        endcase
        mctrl.rd_valid = rd_valid_reg;
    end

    // Build the result of the current item.
    always_comb begin
        result_next = result_reg;
        if (accept) begin
            result_next = '0;
            if (s_data.mode == MODE_INSERT) begin
                if (!port_ok) begin
                    result_next.status = ST_INACTIVE;
                end else if (table_full) begin
                    result_next.status = ST_FULL;
                end else begin
                    result_next.status = ST_INSERTED;
                end
            end else if (ttl_low) begin
                result_next.status = ST_TTL_EXPIRED;
            end else begin
                result_next.status = ST_NO_ROUTE;
            end
        end else if (state_reg == FSM_RESOLVE) begin
            result_next = '0;
            if (!mres.found) begin
                result_next.status = ST_NO_ROUTE;
            end else if (mres.port == lookup_reg.ingress_interface) begin
                result_next.status = ST_BACK_TO_INGRESS;
            end else begin
                result_next.status        = ST_FORWARD;
                result_next.out_interface = mres.port;
                result_next.out_ttl       = lookup_reg.ttl - 8'd1;
            end
        end
    end

    // Advance counters and the output valid.
    always_comb begin
        count_next = count_reg;
        if (wr_en) begin
            count_next = count_reg + CW'(1);
        end
        rd_idx_next = rd_idx_reg;
        if (accept) begin
            rd_idx_next = '0;
        end else if (rd_en) begin
            rd_idx_next = rd_idx_reg + AW'(1);
        end
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= FSM_IDLE;
            active_mask_reg <= 8'd0;
            count_reg       <= '0;
            rd_idx_reg      <= '0;
            rd_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_idx_reg   <= rd_idx_next;
            rd_valid_reg <= rd_en;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                active_mask_reg <= cfg_wr_data;
            end
        end
    end

    // Hold the item payload, the pending result and the output data.
    always_ff @(posedge aclk) begin
        if (accept) begin
            lookup_reg <= s_data;
        end
        result_reg <= result_next;
        if (load_out) begin
            m_data_reg <= result_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    lpr_ram #(
        .WIDTH ($bits(route_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_route_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_route),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_route)
    );

    lpr_match u_match (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mctrl),
        .entry   (rd_route),
        .dest    (lookup_reg.address),
        .res     (mres)
    );

    `LPR_ASSERT(a_wr_not_full, aclk, aresetn,
        !wr_en || (count_reg < CW'(TABLE_DEPTH)), "table write while full")
    `LPR_ASSERT(a_rd_data_in_scan, aclk, aresetn,
        !rd_valid_reg || state_reg == FSM_SCAN || state_reg == FSM_DRAIN,
        "read data outside scan")
    `LPR_ASSERT_NEXT(a_expired_fast, aclk, aresetn,
        accept && s_data.mode == MODE_LOOKUP && ttl_low,
        state_reg == FSM_DONE && result_reg.status == ST_TTL_EXPIRED,
        "expired ttl not resolved at once")
    `LPR_ASSERT_NEXT(a_count_hold, aclk, aresetn, !wr_en, $stable(count_reg),
        "route count moved without insert")

endmodule
